// ===== design/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the LRU timestamp cache
// Command codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int unsigned EntriesDefault = 1024;
  localparam int unsigned CapW           = 11;
  localparam int unsigned KeyW           = 64;
  localparam int unsigned ValW           = 64;
  localparam int unsigned StampW         = 64;
  localparam logic [CapW-1:0] CapacityReset = 11'd1024;

  typedef enum logic [1:0] {
    CMD_FETCH  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage

// ===== design/ltc_ram.sv =====
// ----------------------------------------------------------------------------
// ltc_ram: generic single-port synchronous RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/lru_timestamp_cache_core.sv =====
// Each item takes one scan of the entry memory from input accept to result valid
// A new item is accepted only once the previous result has been taken; one entry read per cycle
// A capacity write below occupancy evicts one entry per scan
// Reset: asynchronous; a clearing pass over every entry empties the memory before any item
// ----------------------------------------------------------------------------
// lru_timestamp_cache_core: fully associative LRU cache, top level
// Scans the entry memory for key match, free slot and oldest stamp.
// ----------------------------------------------------------------------------
module lru_timestamp_cache_core
  import ltc_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  input  logic            value_ok_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            hit_o,
  output logic [ValW-1:0] found_value_o,
  output logic            found_ok_o,
  output logic [CapW-1:0] occupancy_o
);

  localparam int unsigned RW = 1 + KeyW + ValW + 1 + StampW;

  state_e state_q, state_d;
  logic [CapW-1:0]   cap_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [StampW-1:0] clk_cnt_q, clk_cnt_d;
  logic [AW:0]       idx_q, idx_d;
  logic              rvld_q;
  logic [AW-1:0]     radr_q;
  logic              shrink_q, shrink_d;
  logic [1:0]        cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   val_q;
  logic              vok_q;
  logic              fnd_q, fnd_d, fre_q, fre_d, old_q, old_d;
  logic [AW-1:0]     fidx_q, fidx_d, fridx_q, fridx_d, oidx_q, oidx_d;
  logic [AW-1:0]     ins_adr_q, ins_adr_d;
  logic [StampW-1:0] ostamp_q, ostamp_d;
  logic [ValW-1:0]   fval_q, fval_d;
  logic              fok_q, fok_d;
  logic              hit_q, hit_d, rok_q, rok_d;
  logic [ValW-1:0]   rval_q, rval_d;
  logic [CW-1:0]     effcap;
  logic              over_cap;

  logic          we;
  logic [AW-1:0] addr;
  logic [RW-1:0] wdata, rdata;
  logic              r_used;
  logic [KeyW-1:0]   r_key;
  logic [ValW-1:0]   r_val;
  logic              r_ok;
  logic [StampW-1:0] r_stamp;

  assign {r_used, r_key, r_val, r_ok, r_stamp} = rdata;

  ltc_ram #(.Width(RW), .Depth(ENTRIES)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_comb begin
    if (32'(cap_q) > ENTRIES) begin
      effcap = CW'(ENTRIES);
    end else begin
      effcap = CW'(cap_q);
    end
  end

  assign over_cap = (cnt_q > effcap);

  logic scan_done, clear_last;
  assign scan_done  = (idx_q == (AW+1)'(ENTRIES));
  assign clear_last = (idx_q == (AW+1)'(ENTRIES - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (shrink_q || over_cap) state_d = ST_SCAN;
                else if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (scan_done && !rvld_q) state_d = ST_ACT;
      ST_ACT:   state_d = ST_WRITE;
      ST_WRITE: state_d = shrink_q ? ST_IDLE : ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic do_evict, do_ins;
  always_comb begin
    do_evict = 1'b0;
    do_ins   = 1'b0;
    if (shrink_q) begin
      do_evict = old_q;
    end else if ((cmd_q == CMD_FETCH) && !fnd_q && effcap != '0) begin
      do_ins   = 1'b1;
      do_evict = (cnt_q >= effcap) && old_q;
    end
  end

  always_comb begin
    we        = 1'b0;
    addr      = idx_q[AW-1:0];
    wdata     = {1'b1, key_q, val_q, vok_q, clk_cnt_q};
    cnt_d     = cnt_q;
    clk_cnt_d = clk_cnt_q;
    idx_d     = idx_q;
    shrink_d  = shrink_q;
    ins_adr_d = ins_adr_q;
    hit_d = hit_q; rval_d = rval_q; rok_d = rok_q;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + 1'b1;
      end
      ST_IDLE: begin
        idx_d = '0;
        if (over_cap) shrink_d = 1'b1;
      end
      ST_SCAN: if (!scan_done) idx_d = idx_q + 1'b1;
      ST_ACT: begin
        hit_d = 1'b0; rval_d = '0; rok_d = 1'b0;
        if (!shrink_q && fnd_q && cmd_q != CMD_NONE) begin
          hit_d = 1'b1; rval_d = fval_q; rok_d = fok_q;
        end
        if (do_evict) begin
          we    = 1'b1;
          addr  = oidx_q;
          wdata = '0;
          cnt_d = cnt_q - 1'b1;
        end
        ins_adr_d = (fre_q && !(do_evict && oidx_q < fridx_q)) ? fridx_q : oidx_q;
      end
      ST_WRITE: begin
        shrink_d = 1'b0;
        if (!shrink_q) begin
          if (fnd_q && (cmd_q == CMD_FETCH || cmd_q == CMD_LOOKUP)) begin
            we = 1'b1; addr = fidx_q;
            wdata = {1'b1, key_q, fval_q, fok_q, clk_cnt_q};
            clk_cnt_d = clk_cnt_q + 1'b1;
          end else if (fnd_q && cmd_q == CMD_REMOVE && !fok_q) begin
            we = 1'b1; addr = fidx_q;
            wdata = '0;
            cnt_d = cnt_q - 1'b1;
          end else if (do_ins) begin
            we = 1'b1;
            addr = ins_adr_q;
            cnt_d = cnt_q + 1'b1;
            clk_cnt_d = clk_cnt_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // scan compare on registered read data
  always_comb begin
    fnd_d = fnd_q; fidx_d = fidx_q; fval_d = fval_q; fok_d = fok_q;
    fre_d = fre_q; fridx_d = fridx_q;
    old_d = old_q; oidx_d = oidx_q; ostamp_d = ostamp_q;
    if (state_q == ST_IDLE) begin
      fnd_d = 1'b0; fre_d = 1'b0; old_d = 1'b0;
    end else if (state_q == ST_SCAN && rvld_q) begin
      if (r_used) begin
        if (!fnd_q && r_key == key_q) begin
          fnd_d = 1'b1; fidx_d = radr_q; fval_d = r_val; fok_d = r_ok;
        end
        if (!old_q || r_stamp < ostamp_q) begin
          old_d = 1'b1; oidx_d = radr_q; ostamp_d = r_stamp;
        end
      end else if (!fre_q) begin
        fre_d = 1'b1; fridx_d = radr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cap_q     <= CapacityReset;
      cnt_q     <= '0;
      clk_cnt_q <= '0;
      idx_q     <= '0;
      rvld_q    <= 1'b0;
      shrink_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      cnt_q     <= cnt_d;
      clk_cnt_q <= clk_cnt_d;
      idx_q     <= idx_d;
      rvld_q    <= (state_q == ST_SCAN) && !scan_done;
      shrink_q  <= shrink_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radr_q <= idx_q[AW-1:0];
    fnd_q <= fnd_d; fidx_q <= fidx_d; fval_q <= fval_d; fok_q <= fok_d;
    fre_q <= fre_d; fridx_q <= fridx_d;
    old_q <= old_d; oidx_q <= oidx_d; ostamp_q <= ostamp_d;
    ins_adr_q <= ins_adr_d;
    hit_q <= hit_d; rval_q <= rval_d; rok_q <= rok_d;
    if (in_ready_o && in_valid_i) begin
      cmd_q <= command_i; key_q <= key_i; val_q <= value_i; vok_q <= value_ok_i;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE) && !shrink_q && !over_cap;
  assign out_valid_o   = (state_q == ST_OUT);
  assign hit_o         = hit_q;
  assign found_value_o = rval_q;
  assign found_ok_o    = rok_q;
  assign occupancy_o   = CapW'(cnt_q);

endmodule

// ===== design/ltc_checker.sv =====
// ----------------------------------------------------------------------------
// ltc_checker: port-level checks of the LRU timestamp cache
// Handshake and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module ltc_checker
  import ltc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            hit_o,
  input logic [ValW-1:0] found_value_o,
  input logic            found_ok_o,
  input logic [CapW-1:0] occupancy_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_value_o))
    else $error("result dropped while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_value_o == '0 && !found_ok_o)
    else $error("miss carries data");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item accepted while result pending");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= CapW'(1024))
    else $error("occupancy out of range");

endmodule

bind lru_timestamp_cache_core ltc_checker u_ltc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .hit_o, .found_value_o, .found_ok_o, .occupancy_o
);

// ===== sim/tb_lru_timestamp_cache_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_timestamp_cache_core: self-checking bench for the LRU cache core
// Drives fetch-or-insert, lookup, remove and idle commands over several
// capacity settings with random gaps and stalls on both channels, and
// compares every result against an in-bench model of the cache with
// stamp-based eviction.
// ----------------------------------------------------------------------------
module tb_lru_timestamp_cache_core;
  import ltc_pkg::*;

  localparam int unsigned Slots     = EntriesDefault;
  localparam int unsigned SettleCyc = 2 * Slots + 64;
  localparam int unsigned MaxCycles = 4000000;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] value;
    logic            ok;
    logic [CapW-1:0] occ;
  } lookup_res_t;

  class cache_scoreboard;
    logic [KeyW-1:0]   slot_key[Slots];
    logic [ValW-1:0]   slot_val[Slots];
    logic              slot_ok[Slots];
    logic              slot_used[Slots];
    logic [StampW-1:0] slot_stamp[Slots];
    logic [StampW-1:0] access_cnt;
    int unsigned       held;
    int unsigned       cap;
    lookup_res_t       expected_q[$];
    int unsigned       errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      access_cnt = '0;
      held       = 0;
      cap        = CapacityReset;
      errors     = 0;
    endfunction

    function int unsigned limit();
      return (cap > Slots) ? Slots : cap;
    endfunction

    function void drop_oldest();
      int best;
      best = -1;
      for (int i = 0; i < Slots; i++)
        if (slot_used[i] && (best < 0 || slot_stamp[i] < slot_stamp[best])) best = i;
      if (best >= 0) begin
        slot_used[best] = 1'b0;
        if (held > 0) held--;
      end
    endfunction

    function int find(logic [KeyW-1:0] k);
      for (int i = 0; i < Slots; i++)
        if (slot_used[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function void apply_cap(logic [CapW-1:0] c);
      cap = c;
      while (held > limit()) drop_oldest();
    endfunction

    function void note(cmd_e cmd, logic [KeyW-1:0] k, logic [ValW-1:0] v, logic vok);
      lookup_res_t r;
      int idx;
      r = '0;
      if (cmd == CMD_FETCH || cmd == CMD_LOOKUP) begin
        idx = find(k);
        if (idx >= 0) begin
          slot_stamp[idx] = access_cnt;
          access_cnt++;
          r.hit   = 1'b1;
          r.value = slot_val[idx];
          r.ok    = slot_ok[idx];
        end else if (cmd == CMD_FETCH && limit() > 0) begin
          if (held >= limit()) drop_oldest();
          for (int i = 0; i < Slots; i++)
            if (!slot_used[i]) begin
              slot_used[i]  = 1'b1;
              slot_key[i]   = k;
              slot_val[i]   = v;
              slot_ok[i]    = vok;
              slot_stamp[i] = access_cnt;
              access_cnt++;
              held++;
              break;
            end
        end
      end else if (cmd == CMD_REMOVE) begin
        idx = find(k);
        if (idx >= 0) begin
          r.hit   = 1'b1;
          r.value = slot_val[idx];
          r.ok    = slot_ok[idx];
          if (!slot_ok[idx]) begin
            slot_used[idx] = 1'b0;
            if (held > 0) held--;
          end
        end
      end
      r.occ = held[CapW-1:0];
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check(lookup_res_t got);
      lookup_res_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.value, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit) report("hit", got.hit, want.hit);
      if (got.value !== want.value) report("found_value", got.value, want.value);
      if (got.ok !== want.ok) report("found_ok", got.ok, want.ok);
      if (got.occ !== want.occ) report("occupancy", got.occ, want.occ);
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      command_i = '0;
  logic [KeyW-1:0] key_i = '0;
  logic [ValW-1:0] value_i = '0;
  logic            value_ok_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic            hit_o;
  logic [ValW-1:0] found_value_o;
  logic            found_ok_o;
  logic [CapW-1:0] occupancy_o;

  cache_scoreboard sb = new();
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     cycles = 0;
  logic [KeyW-1:0] key_pool[8];

  lru_timestamp_cache_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .key_i, .value_i, .value_ok_i,
    .out_valid_o, .out_ready_i, .hit_o, .found_value_o, .found_ok_o, .occupancy_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    if (in_valid_i && in_ready_o)
      sb.note(cmd_e'(command_i), key_i, value_i, value_ok_i);
    if (out_valid_o && out_ready_i)
      sb.check('{hit_o, found_value_o, found_ok_o, occupancy_o});
  end

  task automatic send_item(cmd_e cmd, logic [KeyW-1:0] k, logic [ValW-1:0] v, logic vok);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= k;
    value_i    <= v;
    value_ok_i <= vok;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] c);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.apply_cap(c);
  endtask

  task automatic random_items(int n);
    cmd_e            cmd;
    logic [KeyW-1:0] k;
    int unsigned     r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      cmd = (r < 50) ? CMD_FETCH : (r < 70) ? CMD_LOOKUP :
            (r < 95) ? CMD_REMOVE : CMD_NONE;
      k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
      send_item(cmd, k, {$urandom, $urandom}, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_LOOKUP, '0, '0, 1'b0);
    send_item(CMD_REMOVE, '0, '0, 1'b0);
    send_item(CMD_FETCH,  '0, '1, 1'b1);
    send_item(CMD_FETCH,  '0, '0, 1'b0);
    send_item(CMD_LOOKUP, '0, '0, 1'b0);
    send_item(CMD_FETCH,  '1, '0, 1'b0);
    send_item(CMD_LOOKUP, '1, '1, 1'b1);
    send_item(CMD_NONE,   '1, '1, 1'b1);
    send_item(CMD_REMOVE, '0, '0, 1'b0);
    send_item(CMD_REMOVE, '1, '1, 1'b1);
    send_item(CMD_LOOKUP, '1, '0, 1'b0);
    send_item(CMD_FETCH,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_item(CMD_FETCH,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
    send_item(CMD_FETCH,  64'h1, 64'h2, 1'b1);
    write_capacity(11'd2);
    send_item(CMD_FETCH,  64'h2, 64'h3, 1'b1);
    send_item(CMD_FETCH,  64'h5555_5555_5555_5555, '0, 1'b0);
    send_item(CMD_FETCH,  64'h3, 64'h4, 1'b0);
    send_item(CMD_LOOKUP, 64'h2, '0, 1'b0);
    send_item(CMD_REMOVE, 64'h3, '0, 1'b0);

    write_capacity(11'd3);
    send_idle_pct = 79;
    random_items(70);

    write_capacity(11'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    random_items(45);

    write_capacity(11'd0);
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    random_items(20);

    write_capacity(11'd2047);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_items(70);

    write_capacity(11'd4);
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    random_items(60);

    drain();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
